// ----- sv/ch_pkg.sv -----
// shared types, constants and round function for the cubehash engine
// no dependencies
package ch_pkg;
  localparam int MAX_BLOCK_BYTES_DEF = 128;
  localparam int NWORDS = 32;
  localparam int ROT_A = 7;
  localparam int ROT_B = 11;
  localparam logic [4:0] LAST_WORD_IDX = 5'b11111;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ABSORB = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;

  localparam logic [2:0] REG_INIT_ROUNDS = 3'd0;
  localparam logic [2:0] REG_BLOCK_ROUNDS = 3'd1;
  localparam logic [2:0] REG_BLOCK_BYTES = 3'd2;
  localparam logic [2:0] REG_FINAL_ROUNDS = 3'd3;
  localparam logic [2:0] REG_DIGEST_BYTES = 3'd4;

  typedef logic [31:0] word_t;
  typedef word_t [NWORDS-1:0] state_t;

  // queued command word between front and back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

  function automatic word_t rotl(word_t v, int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // one full round
  function automatic state_t cube_round(state_t s);
    state_t a;
    state_t b;
    a = s;
    for (int k = 0; k < 16; k++) a[16+k] = a[16+k] + a[k];
    for (int k = 0; k < 16; k++) a[k] = rotl(a[k], ROT_A);
    b = a;
    for (int k = 0; k < 16; k++) b[k] = a[k ^ 8];
    for (int k = 0; k < 16; k++) b[k] = b[k] ^ b[16+k];
    a = b;
    for (int k = 16; k < 32; k++) a[k] = b[k ^ 2];
    for (int k = 0; k < 16; k++) a[16+k] = a[16+k] + a[k];
    for (int k = 0; k < 16; k++) a[k] = rotl(a[k], ROT_B);
    b = a;
    for (int k = 0; k < 16; k++) b[k] = a[k ^ 4];
    for (int k = 0; k < 16; k++) b[k] = b[k] ^ b[16+k];
    a = b;
    for (int k = 16; k < 32; k++) a[k] = b[k ^ 1];
    cube_round = a;
  endfunction
endpackage

// ----- sv/ch_fifo.sv -----
// short command queue between the front and back parts
// depends on ch_pkg
module ch_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ch_pkg::cmd_t  wr_data,
  output logic          full,
  input  logic          rd_en,
  output ch_pkg::cmd_t  rd_data,
  output logic          empty
);
  import ch_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en && !full) wp_r <= ~wp_r;
      if (rd_en && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en && !full) - 2'(rd_en && !empty);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !wr_en) |=> empty) else $error("queue filled without write");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !rd_en) |=> full) else $error("queue drained without read");
`endif
endmodule

// ----- sv/ch_core.sv -----
// back part: state, round unit sequencer and digest output register
// depends on ch_pkg
module ch_core #(
  parameter int MAX_BLOCK_BYTES = ch_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  ch_pkg::cmd_t  cmd,
  output logic          cmd_take,
  input  logic [9:0]    init_rounds,
  input  logic [7:0]    block_rounds,
  input  logic [7:0]    block_bytes,
  input  logic [9:0]    final_rounds,
  input  logic [6:0]    digest_bytes,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [39:0]   out_tdata,
  output logic          out_tlast
);
  import ch_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_BLK   = 3'd2;
  localparam logic [2:0] ST_FBLK  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  state_t      st_r, st_nxt;
  logic [2:0]  fsm_r, fsm_nxt;
  logic [9:0]  rcnt_r, rcnt_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  left_r, left_nxt;
  logic [3:0]  widx_r, widx_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic [2:0]  ovb_r, ovb_nxt;
  logic        ol_r, ol_nxt;
  logic [7:0]  eff_blk;
  logic [6:0]  eff_dig;
  logic [7:0]  pos_inc;
  state_t      rnd;
  state_t      xs;

  assign eff_blk = (block_bytes == 8'd0) ? 8'd1 :
                   (block_bytes > 8'(MAX_BLOCK_BYTES)) ? 8'(MAX_BLOCK_BYTES) : block_bytes;
  assign eff_dig = (digest_bytes == 7'd0) ? 7'd1 :
                   (digest_bytes > 7'd64) ? 7'd64 : digest_bytes;
  assign rnd = cube_round(st_r);
  assign pos_inc = {1'b0, pos_r} + 8'd1;
  assign cmd_take = (fsm_r == ST_IDLE) && cmd_valid;

  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, ovb_r, od_r};
  assign out_tlast = ol_r;

  // state byte xor at the current position
  always_comb begin
    logic [7:0] b;
    xs = st_r;
    b = (cmd.op == OP_FINAL) ? 8'h80 : cmd.data;
    xs[pos_r[6:2]] = st_r[pos_r[6:2]] ^ (32'(b) << {pos_r[1:0], 3'b000});
  end

  // sequencer
  always_comb begin
    logic [31:0] w;
    st_nxt = st_r;
    fsm_nxt = fsm_r;
    rcnt_nxt = rcnt_r;
    pos_nxt = pos_r;
    left_nxt = left_r;
    widx_nxt = widx_r;
    ov_nxt = ov_r;
    od_nxt = od_r;
    ovb_nxt = ovb_r;
    ol_nxt = ol_r;
    w = 32'd0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (fsm_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_START: begin
              st_nxt = '0;
              st_nxt[0] = 32'(eff_dig);
              st_nxt[1] = 32'(eff_blk);
              st_nxt[2] = 32'(block_rounds);
              pos_nxt = 7'd0;
              rcnt_nxt = init_rounds;
              fsm_nxt = ST_INIT;
            end
            OP_ABSORB: begin
              st_nxt = xs;
              if (pos_inc >= eff_blk) begin
                pos_nxt = 7'd0;
                rcnt_nxt = 10'(block_rounds);
                fsm_nxt = ST_BLK;
              end else begin
                pos_nxt = pos_inc[6:0];
              end
            end
            OP_FINAL: begin
              st_nxt = xs;
              pos_nxt = 7'd0;
              rcnt_nxt = 10'(block_rounds);
              fsm_nxt = ST_FBLK;
            end
            default: ;
          endcase
        end
      end
      ST_INIT, ST_BLK: begin
        if (rcnt_r == 10'd0) fsm_nxt = ST_IDLE;
        else begin
          st_nxt = rnd;
          rcnt_nxt = rcnt_r - 10'd1;
        end
      end
      ST_FBLK: begin
        if (rcnt_r == 10'd0) begin
          st_nxt[LAST_WORD_IDX] = st_r[LAST_WORD_IDX] ^ 32'd1;
          rcnt_nxt = final_rounds;
          fsm_nxt = ST_FIN;
        end else begin
          st_nxt = rnd;
          rcnt_nxt = rcnt_r - 10'd1;
        end
      end
      ST_FIN: begin
        if (rcnt_r == 10'd0) begin
          left_nxt = eff_dig;
          widx_nxt = 4'd0;
          fsm_nxt = ST_EMIT;
        end else begin
          st_nxt = rnd;
          rcnt_nxt = rcnt_r - 10'd1;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_tready) begin
          w = st_r[{1'b0, widx_r}];
          ov_nxt = 1'b1;
          ol_nxt = (left_r <= 7'd4);
          if (left_r >= 7'd4) begin
            od_nxt = w;
            ovb_nxt = 3'd4;
          end else begin
            od_nxt = w & ((32'd1 << {left_r[1:0], 3'b000}) - 32'd1);
            ovb_nxt = left_r[2:0];
          end
          if (left_r <= 7'd4) fsm_nxt = ST_IDLE;
          else begin
            left_nxt = left_r - 7'd4;
            widx_nxt = widx_r + 4'd1;
          end
        end
      end
      default: fsm_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      fsm_r <= ST_IDLE;
      pos_r <= 7'd0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      fsm_r <= fsm_nxt;
      pos_r <= pos_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rcnt_r <= rcnt_nxt;
    left_r <= left_nxt;
    widx_r <= widx_nxt;
    od_r <= od_nxt;
    ovb_r <= ovb_nxt;
    ol_r <= ol_nxt;
  end

`ifndef ASSERT_OFF
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> fsm_r == ST_IDLE) else $error("command taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_tready) |=> (ov_r && $stable(od_r))) else $error("word dropped");
  a_pos_final: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == ST_FBLK) |-> (pos_r == 7'd0))
    else $error("block position not cleared by finalize");
`endif
endmodule

// ----- sv/ch_front.sv -----
// front part: input word acceptance and command classification
// depends on ch_pkg
module ch_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic [1:0]    in_tuser,
  input  logic          q_full,
  output logic          q_wr,
  output ch_pkg::cmd_t  q_data
);
  import ch_pkg::*;

  logic seen_r;

  // unused opcode is dropped here and never queued
  assign in_tready = !q_full;
  assign q_wr = in_tvalid && !q_full &&
                (in_tuser == OP_START || in_tuser == OP_ABSORB || in_tuser == OP_FINAL);
  assign q_data = '{op: in_tuser, data: in_tdata};

  always_ff @(posedge clk) begin
    if (!rst_n) seen_r <= 1'b0;
    else if (q_wr) seen_r <= 1'b1;
  end

`ifndef ASSERT_OFF
  a_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> in_tready) else $error("queue write without accept");
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |=> seen_r) else $error("first command flag missing");
  a_op_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> in_tuser != 2'd3) else $error("unused opcode queued");
`endif
endmodule

// ----- sv/cubehash_engine.sv -----
// cubehash engine top level: config registers, front, queue and back
// depends on ch_pkg, ch_front, ch_fifo, ch_core
//
// input words: in_tuser carries the operation (start, absorb, finalize),
// in_tdata the message byte. Result words carry digest_word in tdata[31:0],
// valid_bytes in tdata[34:32] and last_word on out_tlast.
// a word is registered in the queue; the back then takes it while idle.
// an absorb that completes a block makes the back run block_rounds rounds;
// a start makes it run init_rounds rounds; finalize makes it run
// block_rounds rounds, then final_rounds rounds, before it emits the digest,
// one word per cycle while out_tready is high.
// the single round unit does one round per cycle.
// a two-entry queue lets the front accept words while the back runs rounds.
// reset clears the state, block position and config to defaults.
// a stalled out_tready holds the digest word and pauses emission.
// config writes are expected only while the engine is idle.
module cubehash_engine #(
  parameter int MAX_BLOCK_BYTES = ch_pkg::MAX_BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // message_byte
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word, valid_bytes
  output logic        out_tlast,  // last_word
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import ch_pkg::*;

  logic [9:0] init_r, final_r;
  logic [7:0] brnd_r, bbytes_r;
  logic [6:0] dig_r;
  logic       q_wr, q_full, q_empty, take;
  cmd_t       q_in, q_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 10'd160;
      brnd_r <= 8'd16;
      bbytes_r <= 8'd32;
      final_r <= 10'd160;
      dig_r <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INIT_ROUNDS:  init_r <= cfg_data;
        REG_BLOCK_ROUNDS: brnd_r <= cfg_data[7:0];
        REG_BLOCK_BYTES:  bbytes_r <= cfg_data[7:0];
        REG_FINAL_ROUNDS: final_r <= cfg_data;
        REG_DIGEST_BYTES: dig_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  ch_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_full, .q_wr, .q_data(q_in)
  );

  ch_fifo u_fifo (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(q_in), .full(q_full),
    .rd_en(take), .rd_data(q_out), .empty(q_empty)
  );

  ch_core #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_core (
    .clk, .rst_n, .cmd_valid(!q_empty), .cmd(q_out), .cmd_take(take),
    .init_rounds(init_r), .block_rounds(brnd_r), .block_bytes(bbytes_r),
    .final_rounds(final_r), .digest_bytes(dig_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );
endmodule
